FILE: sv/lahc_pkg.sv
// ----------------------------------------------------------------------------
// Link attach handshake controller package
// Shared types, constants and lookup functions for the controller.
// ----------------------------------------------------------------------------
package lahc_pkg;

   // Handshake string length and the width of the byte counter
   localparam int MATCH_LENGTH = 10;
   localparam int CNT_W        = 4;

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Configuration register widths and reset values
   localparam int POLL_W        = 10;
   localparam int TIMEOUT_W     = 12;
   localparam int CSR_DATA_W    = 12;
   localparam int CSR_ADDR_W    = 1;
   localparam logic [POLL_W-1:0]    POLL_RESET    = 10'd50;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd2000;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_POLL_INTERVAL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HS_TIMEOUT    = 1'd1;

   // Input word codes
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_UART   = 2'd1;
   localparam logic [1:0] FUNC_STATUS = 2'd2;

   // Result word codes
   localparam logic [1:0] KIND_READ_REQ = 2'd0;
   localparam logic [1:0] KIND_REPLY    = 2'd1;
   localparam logic [1:0] KIND_WRITE    = 2'd2;
   localparam logic [1:0] KIND_FAIL     = 2'd3;

   // Special byte values
   localparam logic [7:0] STX_BYTE  = 8'h02;
   localparam logic [7:0] LATCH_BIT = 8'h10;

   // Saturation limits of the tick counters
   localparam logic [POLL_W-1:0]    POLL_MAX    = '1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = '1;

   // One queued job: the results that one input word causes
   typedef struct packed {
      logic       poll;
      logic       fail;
      logic       reply;
      logic       write;
      logic [7:0] wdata;
      logic       active;
   } job_type;

   // Steps of the result sequencer in the back end
   typedef enum logic [3:0] {
      STEP_POLL,
      STEP_FAIL,
      STEP_R0,
      STEP_R1,
      STEP_R2,
      STEP_R3,
      STEP_R4,
      STEP_R5,
      STEP_WRITE
   } step_type;

   // Expected handshake text; positions past the text expect zero
   function automatic logic [7:0] expected_char(input logic [CNT_W-1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h69;  // i
         4'd1:    ch = 8'h61;  // a
         4'd2:    ch = 8'h6d;  // m
         4'd3:    ch = 8'h66;  // f
         4'd4:    ch = 8'h30;  // 0
         4'd5:    ch = 8'h72;  // r
         4'd6:    ch = 8'h75;  // u
         4'd7:    ch = 8'h70;  // p
         4'd8:    ch = 8'h6d;  // m
         4'd9:    ch = 8'h35;  // 5
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/link_attach_handshake_controller_core.sv
// ----------------------------------------------------------------------------
// Link attach handshake controller
// Polls the attach status, runs the text handshake and reports results.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word contents
//  req_    | in        | tuser func; tdata byte_value, read_ok
//  rsp_    | out       | tuser kind; tdata data, link_active; tlast last
//  csr_    | in        | write enable, register index, write data
//
// An input word is taken whenever the job queue has room, so
// words may arrive back to back. Each word yields zero to seven result words,
// issued by the back end at one per cycle; that sequencer sets the sustained
// rate when results are dense. Reset is synchronous and active high. A stall
// on the result side fills the job queue and only then holds off input.
// ----------------------------------------------------------------------------
module link_attach_handshake_controller_core #(
   parameter int MatchLength = lahc_pkg::MATCH_LENGTH,
   parameter int QueueDepth  = lahc_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lahc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lahc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // [7:0] byte_value, [8] read_ok
   input  logic [1:0]                      req_tuser,  // [1:0] func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // [7:0] data, [8] link_active
   output logic [1:0]                      rsp_tuser,  // [1:0] kind
   output logic                            rsp_tlast
);

   logic              in_accept;
   logic              job_push;
   lahc_pkg::job_type push_job;
   logic              q_full;
   logic              q_pop;
   logic              head_valid;
   lahc_pkg::job_type head_job;
   logic [7:0]        rsp_data;
   logic              rsp_active;

   assign req_tready = !q_full;
   assign in_accept  = req_tvalid && req_tready;

   lahc_front #(
      .MatchLength (MatchLength)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .in_accept  (in_accept),
      .in_func    (req_tuser),
      .in_byte    (req_tdata[7:0]),
      .in_read_ok (req_tdata[8]),
      .job_push   (job_push),
      .job        (push_job)
   );

   lahc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lahc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_tlast),
      .rsp_active (rsp_active)
   );

   assign rsp_tdata = {7'b0, rsp_active, rsp_data};

endmodule

FILE: sv/lahc_front.sv
// ----------------------------------------------------------------------------
// Link attach handshake controller front end
// Accepts input words, keeps the link state and queues a job for each word with results.
// ----------------------------------------------------------------------------
module lahc_front #(
   parameter int MatchLength = lahc_pkg::MATCH_LENGTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lahc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lahc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                in_accept,
   input  logic [1:0]                          in_func,
   input  logic [7:0]                          in_byte,
   input  logic                                in_read_ok,
   output logic                                job_push,
   output lahc_pkg::job_type                   job
);

   localparam logic [lahc_pkg::CNT_W-1:0] MatchLen = lahc_pkg::CNT_W'(MatchLength);

   // Configuration registers
   logic [lahc_pkg::POLL_W-1:0]    poll_interval_ff;
   logic [lahc_pkg::TIMEOUT_W-1:0] hs_timeout_ff;

   // Link state
   logic                           active_ff,      active_in;
   logic                           in_hs_ff,       in_hs_in;
   logic [lahc_pkg::CNT_W-1:0]     rcv_cnt_ff,     rcv_cnt_in;
   logic                           match_ff,       match_in;
   logic [7:0]                     held_byte_ff,   held_byte_in;
   logic                           held_valid_ff,  held_valid_in;
   logic [lahc_pkg::POLL_W-1:0]    poll_ticks_ff,  poll_ticks_in;
   logic                           never_polled_ff, never_polled_in;
   logic                           awaiting_ff,    awaiting_in;
   logic [lahc_pkg::TIMEOUT_W-1:0] hs_ticks_ff,    hs_ticks_in;
   logic                           pend_ff,        pend_in;
   logic [7:0]                     saved_ff,       saved_in;

   // Handshake byte evaluation
   logic [7:0]                 hb_byte;
   logic [lahc_pkg::CNT_W-1:0] hb_cnt_old;
   logic                       hb_match_old;
   logic [lahc_pkg::CNT_W-1:0] hb_cnt;
   logic                       hb_match;
   logic                       hb_done;

   logic [lahc_pkg::POLL_W-1:0] poll_ticks_inc;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= lahc_pkg::POLL_RESET;
         hs_timeout_ff    <= lahc_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            lahc_pkg::CSR_POLL_INTERVAL: poll_interval_ff <= csr_wdata[lahc_pkg::POLL_W-1:0];
            lahc_pkg::CSR_HS_TIMEOUT:    hs_timeout_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A UART word continues the running handshake; a status reply starts a
   // new one from the held byte.
   assign hb_byte      = (in_func == lahc_pkg::FUNC_UART) ? in_byte : held_byte_ff;
   assign hb_cnt_old   = (in_func == lahc_pkg::FUNC_UART) ? rcv_cnt_ff : '0;
   assign hb_match_old = (in_func == lahc_pkg::FUNC_UART) ? match_ff : 1'b1;

   always_comb begin
      hb_cnt   = hb_cnt_old;
      hb_match = hb_match_old;
      hb_done  = 1'b0;
      if (hb_byte == lahc_pkg::STX_BYTE) begin
         hb_cnt   = '0;
         hb_match = 1'b1;
      end else begin
         if (hb_cnt_old < MatchLen) begin
            if (hb_byte != lahc_pkg::expected_char(hb_cnt_old)) begin
               hb_match = 1'b0;
            end
            hb_cnt = hb_cnt_old + 1'b1;
         end
         if (hb_cnt == MatchLen) begin
            if (hb_match) begin
               hb_done = 1'b1;
            end else begin
               hb_cnt   = '0;
               hb_match = 1'b1;
            end
         end
      end
   end

   assign poll_ticks_inc = (poll_ticks_ff != lahc_pkg::POLL_MAX) ?
                           poll_ticks_ff + 1'b1 : poll_ticks_ff;

   // Next link state and the job for the current word
   always_comb begin
      active_in       = active_ff;
      in_hs_in        = in_hs_ff;
      rcv_cnt_in      = rcv_cnt_ff;
      match_in        = match_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      poll_ticks_in   = poll_ticks_ff;
      never_polled_in = never_polled_ff;
      awaiting_in     = awaiting_ff;
      hs_ticks_in     = hs_ticks_ff;
      pend_in         = pend_ff;
      saved_in        = saved_ff;
      job             = '0;

      unique case (in_func)
         lahc_pkg::FUNC_TICK: begin
            poll_ticks_in = poll_ticks_inc;
            if (in_hs_ff) begin
               if (hs_ticks_ff >= hs_timeout_ff) begin
                  // Timeout ends the handshake as failed
                  in_hs_in   = 1'b0;
                  rcv_cnt_in = '0;
                  match_in   = 1'b1;
                  active_in  = 1'b0;
                  job.fail   = 1'b1;
                  job.write  = pend_ff;
                  job.wdata  = saved_ff | lahc_pkg::LATCH_BIT;
                  pend_in    = 1'b0;
               end else if (hs_ticks_ff != lahc_pkg::TIMEOUT_MAX) begin
                  hs_ticks_in = hs_ticks_ff + 1'b1;
               end
            end else if (!awaiting_ff) begin
               if (never_polled_ff || poll_ticks_inc >= poll_interval_ff) begin
                  never_polled_in = 1'b0;
                  poll_ticks_in   = '0;
                  awaiting_in     = 1'b1;
                  job.poll        = 1'b1;
               end
            end
         end
         lahc_pkg::FUNC_UART: begin
            if (in_hs_ff) begin
               rcv_cnt_in = hb_cnt;
               match_in   = hb_match;
               if (hb_done) begin
                  in_hs_in   = 1'b0;
                  rcv_cnt_in = '0;
                  match_in   = 1'b1;
                  active_in  = 1'b1;
                  job.reply  = 1'b1;
                  job.write  = pend_ff;
                  job.wdata  = saved_ff | lahc_pkg::LATCH_BIT;
                  pend_in    = 1'b0;
               end
            end else begin
               held_byte_in  = in_byte;
               held_valid_in = 1'b1;
            end
         end
         lahc_pkg::FUNC_STATUS: begin
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               if (in_read_ok) begin
                  if (in_byte[7:6] == 2'b00) begin
                     active_in = 1'b0;
                  end else if (held_valid_ff) begin
                     // The held byte is the first byte of the handshake
                     in_hs_in      = 1'b1;
                     hs_ticks_in   = '0;
                     held_valid_in = 1'b0;
                     rcv_cnt_in    = hb_cnt;
                     match_in      = hb_match;
                     if (hb_done) begin
                        in_hs_in   = 1'b0;
                        rcv_cnt_in = '0;
                        match_in   = 1'b1;
                        active_in  = 1'b1;
                        job.reply  = 1'b1;
                     end
                  end
                  // Latch clear waits while a handshake runs
                  if ((in_byte & lahc_pkg::LATCH_BIT) != 8'h00) begin
                     if (in_hs_in) begin
                        pend_in  = 1'b1;
                        saved_in = in_byte;
                     end else begin
                        job.write = 1'b1;
                        job.wdata = in_byte | lahc_pkg::LATCH_BIT;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      job.active = active_in;
   end

   assign job_push = in_accept && (job.poll || job.fail || job.reply || job.write);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         in_hs_ff        <= 1'b0;
         rcv_cnt_ff      <= '0;
         match_ff        <= 1'b1;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         poll_ticks_ff   <= '0;
         never_polled_ff <= 1'b1;
         awaiting_ff     <= 1'b0;
         hs_ticks_ff     <= '0;
         pend_ff         <= 1'b0;
         saved_ff        <= '0;
      end else if (in_accept) begin
         active_ff       <= active_in;
         in_hs_ff        <= in_hs_in;
         rcv_cnt_ff      <= rcv_cnt_in;
         match_ff        <= match_in;
         held_byte_ff    <= held_byte_in;
         held_valid_ff   <= held_valid_in;
         poll_ticks_ff   <= poll_ticks_in;
         never_polled_ff <= never_polled_in;
         awaiting_ff     <= awaiting_in;
         hs_ticks_ff     <= hs_ticks_in;
         pend_ff         <= pend_in;
         saved_ff        <= saved_in;
      end
   end

endmodule

FILE: sv/lahc_queue.sv
// ----------------------------------------------------------------------------
// Link attach handshake controller job queue
// Small first-in first-out buffer of jobs between front and back.
// ----------------------------------------------------------------------------
module lahc_queue #(
   parameter int Depth = lahc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lahc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lahc_pkg::job_type head_job
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);

   lahc_pkg::job_type slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff,  count_in;

   assign full       = (count_ff == DepthCnt);
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/lahc_back.sv
// ----------------------------------------------------------------------------
// Link attach handshake controller back end
// Expands each queued job into its result words, one per cycle unless the result side stalls.
// ----------------------------------------------------------------------------
module lahc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  lahc_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_data,
   output logic              rsp_last,
   output logic              rsp_active
);

   lahc_pkg::step_type step_ff, step_in;
   logic               started_ff, started_in;
   lahc_pkg::step_type first_step;
   lahc_pkg::step_type cur_step;
   lahc_pkg::step_type nxt_step;
   logic               has_next;
   logic [1:0]         cur_kind;
   logic [7:0]         cur_data;
   logic               load;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_last_ff;
   logic               rsp_active_ff;

   // First result of a fresh job
   always_comb begin
      priority if (head_job.poll) begin
         first_step = lahc_pkg::STEP_POLL;
      end else if (head_job.fail) begin
         first_step = lahc_pkg::STEP_FAIL;
      end else if (head_job.reply) begin
         first_step = lahc_pkg::STEP_R0;
      end else begin
         first_step = lahc_pkg::STEP_WRITE;
      end
   end

   assign cur_step = started_ff ? step_ff : first_step;
   assign load     = head_valid && (!rsp_valid_ff || rsp_tready);

   // Next step of the sequence
   always_comb begin
      nxt_step = lahc_pkg::STEP_WRITE;
      has_next = 1'b0;
      unique case (cur_step)
         lahc_pkg::STEP_POLL:  has_next = 1'b0;
         lahc_pkg::STEP_FAIL:  has_next = head_job.write;
         lahc_pkg::STEP_R0:    begin nxt_step = lahc_pkg::STEP_R1; has_next = 1'b1; end
         lahc_pkg::STEP_R1:    begin nxt_step = lahc_pkg::STEP_R2; has_next = 1'b1; end
         lahc_pkg::STEP_R2:    begin nxt_step = lahc_pkg::STEP_R3; has_next = 1'b1; end
         lahc_pkg::STEP_R3:    begin nxt_step = lahc_pkg::STEP_R4; has_next = 1'b1; end
         lahc_pkg::STEP_R4:    begin nxt_step = lahc_pkg::STEP_R5; has_next = 1'b1; end
         lahc_pkg::STEP_R5:    has_next = head_job.write;
         lahc_pkg::STEP_WRITE: has_next = 1'b0;
         default:              has_next = 1'b0;
      endcase
   end

   // Result word for the current step
   always_comb begin
      cur_kind = lahc_pkg::KIND_REPLY;
      cur_data = 8'h00;
      unique case (cur_step)
         lahc_pkg::STEP_POLL:  cur_kind = lahc_pkg::KIND_READ_REQ;
         lahc_pkg::STEP_FAIL:  cur_kind = lahc_pkg::KIND_FAIL;
         lahc_pkg::STEP_R0:    cur_data = 8'h04;
         lahc_pkg::STEP_R1:    cur_data = 8'h00;
         lahc_pkg::STEP_R2:    cur_data = 8'h79;  // y
         lahc_pkg::STEP_R3:    cur_data = 8'h65;  // e
         lahc_pkg::STEP_R4:    cur_data = 8'h73;  // s
         lahc_pkg::STEP_R5:    cur_data = 8'h00;
         lahc_pkg::STEP_WRITE: begin
            cur_kind = lahc_pkg::KIND_WRITE;
            cur_data = head_job.wdata;
         end
         default: ;
      endcase
   end

   // Sequencer state and queue pop
   always_comb begin
      step_in    = step_ff;
      started_in = started_ff;
      pop        = 1'b0;
      if (load) begin
         if (has_next) begin
            step_in    = nxt_step;
            started_in = 1'b1;
         end else begin
            started_in = 1'b0;
            pop        = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= lahc_pkg::STEP_POLL;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff   <= cur_kind;
         rsp_data_ff   <= cur_data;
         rsp_last_ff   <= !has_next;
         rsp_active_ff <= head_job.active;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_active = rsp_active_ff;

endmodule
